/* hdl/rbad_pkg.sv */
// Shared types, constants and helpers for the RGB block-average downscaler.
// Used by every module of the block but rbad_ram; depends on nothing.
`default_nettype none

package rbad_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;
    localparam int MAX_BLOCK   = 256;

    localparam int DIM_W       = 13;
    localparam int BLK_W       = 9;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int POS_W       = $clog2(MAX_BLOCK);
    localparam int EXT_W       = DIM_W + 1;
    localparam int CHAN_W      = 8;
    localparam int SUM_W       = 24;
    localparam int AREA_W      = 2 * BLK_W - 1;
    localparam int LANES       = 3;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = DIM_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_WIDTH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_HEIGHT  = 2'd3;

    localparam logic [DIM_W-1:0]  SOURCE_WIDTH_RST  = 13'd256;
    localparam logic [DIM_W-1:0]  SOURCE_HEIGHT_RST = 13'd256;
    localparam logic [BLK_W-1:0]  BLOCK_WIDTH_RST   = 9'd16;
    localparam logic [BLK_W-1:0]  BLOCK_HEIGHT_RST  = 9'd16;

    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [CHAN_W-1:0] CHAN_MAX     = 8'hFF;

    typedef struct packed {
        logic [23:0] source_color;
        logic        frame_start;
    } in_t;

    typedef struct packed {
        logic [31:0] dest_pixel;
        logic        frame_end;
    } out_t;

    typedef logic [LANES-1:0][SUM_W-1:0] sums_t;

    typedef struct packed {
        logic [COL_W-1:0] addr;
        logic [23:0]      color;
        logic             first;
        logic             emit;
        logic             last;
    } job_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [BLK_W-1:0] clamp_blk(input logic [BLK_W-1:0] v);
        logic [BLK_W-1:0] r;
        if (v == '0) begin
            r = BLK_W'(1);
        end else if (v > BLK_W'(MAX_BLOCK)) begin
            r = BLK_W'(MAX_BLOCK);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/rbad_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package dependency.
`default_nettype none

module rbad_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output      logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* hdl/rbad_fifo.sv */
// Short job queue between the classifying front end and the accumulator back end.
// Depends on rbad_pkg (job_t, queue sizing).
`default_nettype none

module rbad_fifo import rbad_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire job_t push_job,
    output      logic full,
    input  wire logic pop,
    output job_t      pop_job,
    output      logic not_empty
);

    job_t                mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_CW-1:0] count_reg;
    logic [QUEUE_CW-1:0] count_next;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QUEUE_CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QUEUE_CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign pop_job   = mem_reg[rd_ptr_reg];
    assign full      = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0)
        else $error("pop from empty queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full || pop)
        else $error("push into full queue");

endmodule

`default_nettype wire

/* hdl/rbad_front.sv */
// Front end: configuration registers, raster position tracking and block classification.
// Depends on rbad_pkg; pushes accumulate jobs into rbad_fifo.
`default_nettype none

module rbad_front import rbad_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                  s_valid,
    output      logic                  s_ready,
    input  wire in_t                   s_data,
    input  wire logic                  q_full,
    output      logic                  q_push,
    output job_t                       q_job,
    output      logic [AREA_W-1:0]     area
);

    logic [DIM_W-1:0]  src_w_reg;
    logic [DIM_W-1:0]  src_h_reg;
    logic [BLK_W-1:0]  blk_w_reg;
    logic [BLK_W-1:0]  blk_h_reg;
    logic [AREA_W-1:0] area_reg;
    logic [AREA_W-1:0] area_next;

    logic [COL_W-1:0]  col_reg,  col_next;
    logic [COL_W-1:0]  row_reg,  row_next;
    logic [COL_W-1:0]  bcol_reg, bcol_next;
    logic [POS_W-1:0]  px_reg,   px_next;
    logic [POS_W-1:0]  py_reg,   py_next;

    logic [DIM_W-1:0]  w, h;
    logic [BLK_W-1:0]  bw, bh;
    logic [COL_W-1:0]  col_cur, row_cur, bcol_cur;
    logic [POS_W-1:0]  px_cur, py_cur;
    logic [EXT_W-1:0]  x_end, y_end;
    logic              in_x, in_y, last_x, last_y, hit_x, hit_y;
    logic              col_wrap, row_wrap, px_wrap, py_wrap;
    logic              accept;

    assign w  = clamp_dim(src_w_reg, DIM_W'(MAX_WIDTH));
    assign h  = clamp_dim(src_h_reg, DIM_W'(MAX_HEIGHT));
    assign bw = clamp_blk(blk_w_reg);
    assign bh = clamp_blk(blk_h_reg);

    assign area_next = {{(AREA_W-BLK_W){1'b0}}, bw} * {{(AREA_W-BLK_W){1'b0}}, bh};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_w_reg <= SOURCE_WIDTH_RST;
            src_h_reg <= SOURCE_HEIGHT_RST;
            blk_w_reg <= BLOCK_WIDTH_RST;
            blk_h_reg <= BLOCK_HEIGHT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SOURCE_WIDTH: begin
                    src_w_reg <= cfg_wr_data;
                end
                REG_SOURCE_HEIGHT: begin
                    src_h_reg <= cfg_wr_data;
                end
                REG_BLOCK_WIDTH: begin
                    blk_w_reg <= cfg_wr_data[BLK_W-1:0];
                end
                REG_BLOCK_HEIGHT: begin
                    blk_h_reg <= cfg_wr_data[BLK_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        area_reg <= area_next;
    end

    assign accept  = s_valid && s_ready;
    assign s_ready = !q_full;

    assign col_cur  = s_data.frame_start ? '0 : col_reg;
    assign row_cur  = s_data.frame_start ? '0 : row_reg;
    assign bcol_cur = s_data.frame_start ? '0 : bcol_reg;
    assign px_cur   = s_data.frame_start ? '0 : px_reg;
    assign py_cur   = s_data.frame_start ? '0 : py_reg;

    // block end position; the block is whole when it fits inside the row and frame
    assign x_end  = EXT_W'(col_cur) - EXT_W'(px_cur) + EXT_W'(bw);
    assign y_end  = EXT_W'(row_cur) - EXT_W'(py_cur) + EXT_W'(bh);
    assign in_x   = x_end <= EXT_W'(w);
    assign in_y   = y_end <= EXT_W'(h);
    assign last_x = (x_end + EXT_W'(bw)) > EXT_W'(w);
    assign last_y = (y_end + EXT_W'(bh)) > EXT_W'(h);
    assign hit_x  = BLK_W'(px_cur) == (bw - BLK_W'(1));
    assign hit_y  = BLK_W'(py_cur) == (bh - BLK_W'(1));

    assign col_wrap = (DIM_W'(col_cur) + DIM_W'(1)) >= w;
    assign row_wrap = (DIM_W'(row_cur) + DIM_W'(1)) >= h;
    assign px_wrap  = (BLK_W'(px_cur) + BLK_W'(1)) >= bw;
    assign py_wrap  = (BLK_W'(py_cur) + BLK_W'(1)) >= bh;

    always_comb begin
        col_next  = col_cur;
        row_next  = row_cur;
        bcol_next = bcol_cur;
        px_next   = px_cur;
        py_next   = py_cur;
        if (col_wrap) begin
            col_next  = '0;
            px_next   = '0;
            bcol_next = '0;
            if (row_wrap) begin
                row_next = '0;
                py_next  = '0;
            end else begin
                row_next = row_cur + COL_W'(1);
                py_next  = py_wrap ? '0 : py_cur + POS_W'(1);
            end
        end else begin
            col_next = col_cur + COL_W'(1);
            if (px_wrap) begin
                px_next   = '0;
                bcol_next = bcol_cur + COL_W'(1);
            end else begin
                px_next = px_cur + POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            bcol_reg <= '0;
            px_reg   <= '0;
            py_reg   <= '0;
        end else if (accept) begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            bcol_reg <= bcol_next;
            px_reg   <= px_next;
            py_reg   <= py_next;
        end
    end

    assign q_push      = accept && in_x && in_y;
    assign q_job.addr  = bcol_cur;
    assign q_job.color = s_data.source_color;
    assign q_job.first = (px_cur == '0) && (py_cur == '0);
    assign q_job.emit  = hit_x && hit_y;
    assign q_job.last  = last_x && last_y;
    assign area        = area_reg;

endmodule

`default_nettype wire

/* hdl/rbad_div.sv */
// Three-lane restoring divider: channel sums by block area, one quotient bit per cycle.
// Depends on rbad_pkg; holds the packed ARGB result until the output stage takes it.
`default_nettype none

module rbad_div import rbad_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire sums_t             sums,
    input  wire logic [AREA_W-1:0] area,
    input  wire logic              last,
    output      logic              idle,
    output      logic              done,
    input  wire logic              take,
    output out_t                   result
);

    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                          state_reg, state_next;
    logic [STEP_W-1:0]                   step_reg;
    logic [AREA_W-1:0]                   area_reg;
    logic                                last_reg;
    logic [LANES-1:0][AREA_W-1:0]        rem_reg;
    logic [LANES-1:0][SUM_W-1:0]         dq_reg;
    logic [LANES-1:0][AREA_W-1:0]        rem_next;
    logic [LANES-1:0][SUM_W-1:0]         dq_next;
    logic [LANES-1:0][CHAN_W-1:0]        quot;

    always_comb begin
        logic [AREA_W:0] shifted;
        logic            ge;
        for (int l = 0; l < LANES; l++) begin
            shifted     = {rem_reg[l], dq_reg[l][SUM_W-1]};
            ge          = shifted >= {1'b0, area_reg};
            rem_next[l] = ge ? AREA_W'(shifted - {1'b0, area_reg}) : shifted[AREA_W-1:0];
            dq_next[l]  = {dq_reg[l][SUM_W-2:0], ge};
            quot[l]     = (|dq_reg[l][SUM_W-1:CHAN_W]) ? CHAN_MAX : dq_reg[l][CHAN_W-1:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (step_reg == STEP_W'(SUM_W - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (take) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && start) begin
            step_reg <= '0;
            area_reg <= area;
            last_reg <= last;
            rem_reg  <= '0;
            dq_reg   <= sums;
        end else if (state_reg == ST_RUN) begin
            step_reg <= step_reg + STEP_W'(1);
            rem_reg  <= rem_next;
            dq_reg   <= dq_next;
        end
    end

    assign idle              = (state_reg == ST_IDLE);
    assign done              = (state_reg == ST_DONE);
    assign result.dest_pixel = {ALPHA_OPAQUE, quot[2], quot[1], quot[0]};
    assign result.frame_end  = last_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RUN |-> step_reg <= STEP_W'(SUM_W - 1))
        else $error("divider step count overran");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> rem_reg[0] < area_reg && rem_reg[1] < area_reg
                                 && rem_reg[2] < area_reg)
        else $error("divider remainder not below divisor");

    assert property (@(posedge aclk) disable iff (!aresetn)
        take |-> state_reg == ST_DONE)
        else $error("divider result taken before done");

endmodule

`default_nettype wire

/* hdl/rbad_back.sv */
// Back end: per-column accumulator RAM with read-modify-write and forwarding,
// divider launch and the output register. Depends on rbad_pkg, rbad_ram, rbad_div.
`default_nettype none

module rbad_back import rbad_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_not_empty,
    input  wire job_t              q_job,
    output      logic              q_pop,
    input  wire logic [AREA_W-1:0] area,
    output      logic              m_valid,
    input  wire logic              m_ready,
    output out_t                   m_data
);

    logic   b_valid_reg;
    job_t   b_job_reg;
    logic   fwd_reg;
    sums_t  fwd_sum_reg;
    sums_t  rd_sums;
    sums_t  base;
    sums_t  sum;
    logic   b_fire;
    logic   div_idle;
    logic   div_done;
    logic   div_take;
    out_t   div_result;
    logic   m_valid_reg;
    out_t   m_data_reg;

    rbad_ram #(
        .DATA_W ($bits(sums_t)),
        .DEPTH  (MAX_WIDTH)
    ) u_acc_ram (
        .aclk    (aclk),
        .wr_en   (b_fire),
        .wr_addr (b_job_reg.addr),
        .wr_data (sum),
        .rd_en   (q_pop),
        .rd_addr (q_job.addr),
        .rd_data (rd_sums)
    );

    always_comb begin
        if (b_job_reg.first) begin
            base = '0;
        end else if (fwd_reg) begin
            base = fwd_sum_reg;
        end else begin
            base = rd_sums;
        end
        for (int l = 0; l < LANES; l++) begin
            sum[l] = base[l] + SUM_W'(b_job_reg.color[CHAN_W*l +: CHAN_W]);
        end
    end

    assign b_fire = b_valid_reg && (!b_job_reg.emit || div_idle);
    assign q_pop  = q_not_empty && (!b_valid_reg || b_fire);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (q_pop) begin
            b_valid_reg <= 1'b1;
        end else if (b_fire) begin
            b_valid_reg <= 1'b0;
        end
    end

    // the beat ahead writes as this one reads; take its sum instead of the RAM data
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            b_job_reg   <= q_job;
            fwd_reg     <= b_fire && (b_job_reg.addr == q_job.addr);
            fwd_sum_reg <= sum;
        end
    end

    rbad_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (b_fire && b_job_reg.emit),
        .sums    (sum),
        .area    (area),
        .last    (b_job_reg.last),
        .idle    (div_idle),
        .done    (div_done),
        .take    (div_take),
        .result  (div_result)
    );

    assign div_take = div_done && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (div_take) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (div_take) begin
            m_data_reg <= div_result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

/* hdl/rgb_block_average_downscale_top.sv */
// Top level of the RGB block-average downscaler: front end, job queue, back end.
// Depends on rbad_pkg, rbad_front, rbad_fifo, rbad_back.
//
//   port group   dir  handshake            beat
//   cfg_*        in   cfg_wr_en            cfg_index selects register, cfg_wr_data value
//   s_*          in   s_valid / s_ready    in_t: source_color, frame_start
//   m_*          out  m_valid / m_ready    out_t: dest_pixel, frame_end
//
// One source pixel per cycle while the four-entry queue has room; the accumulator
// stage retires one beat per cycle (RAM read, then add and write with forwarding)
// unless a block's last pixel waits on a busy divider. That last pixel starts the
// divider, which takes no new block until its result is in the output register
// and it is back to idle; small blocks are paced by it.
// Reset is synchronous, active low; the accumulator RAM needs no clearing pass.
// A stalled m_ready fills the divider, then the accumulator stage, then the queue.
`default_nettype none

module rgb_block_average_downscale_top import rbad_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                  s_valid,
    output      logic                  s_ready,
    input  wire in_t                   s_data,
    output      logic                  m_valid,
    input  wire logic                  m_ready,
    output out_t                       m_data
);

    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              q_not_empty;
    job_t              push_job;
    job_t              pop_job;
    logic [AREA_W-1:0] area;

    rbad_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_job       (push_job),
        .area        (area)
    );

    rbad_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .pop_job   (pop_job),
        .not_empty (q_not_empty)
    );

    rbad_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_job       (pop_job),
        .q_pop       (q_pop),
        .area        (area),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

`default_nettype wire
